// ===== rtl/stl_pkg.sv =====
`timescale 1ns / 1ps

package stl_pkg;

  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QUEUE_AW      = $clog2(QUEUE_DEPTH);

  // token type codes
  localparam logic [3:0] TOK_PRE   = 4'd0;
  localparam logic [3:0] TOK_IDENT = 4'd1;
  localparam logic [3:0] TOK_PRIM  = 4'd2;
  localparam logic [3:0] TOK_NUM   = 4'd3;
  localparam logic [3:0] TOK_STR   = 4'd4;
  localparam logic [3:0] TOK_TERM  = 4'd5;
  localparam logic [3:0] TOK_PUNCT = 4'd6;
  localparam logic [3:0] TOK_ARITH = 4'd7;
  localparam logic [3:0] TOK_SCOPE = 4'd8;
  localparam logic [3:0] TOK_ERR   = 4'd9;

  // two- and three-letter primitive type names, packed as bytes
  localparam logic [23:0] PRIM2 [3] = '{24'h005530, 24'h005538, 24'h004938};
  localparam logic [23:0] PRIM3 [7] = '{24'h553136, 24'h553332, 24'h553634,
                                        24'h493136, 24'h493332, 24'h493634,
                                        24'h463634};

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_type;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
    logic        end_of_stream;
  } token_t;

  // up to two tokens caused by one byte
  typedef struct packed {
    token_t tok0;
    token_t tok1;
    logic   two;
  } bundle_t;

  typedef struct packed {
    logic push;
    logic full;
  } queue_wr_status_t;

  function automatic logic [15:0] pos_to_start(input logic [POSITION_BITS-1:0] pos);
    logic [31:0] wide;
    wide = 32'(pos);
    return wide[15:0];
  endfunction

  function automatic logic [3:0] ident_type(input logic [15:0] len, input logic [23:0] pref);
    logic hit;
    hit = 1'b0;
    if (len == 16'd2) begin
      for (int i = 0; i < 3; i++) hit |= (pref == PRIM2[i]);
    end else if (len == 16'd3) begin
      for (int i = 0; i < 7; i++) hit |= (pref == PRIM3[i]);
    end
    return hit ? TOK_PRIM : TOK_IDENT;
  endfunction

endpackage

// ===== rtl/source_text_lexer.sv =====
`timescale 1ns / 1ps

// source_text_lexer takes one source byte per transfer and returns token
// descriptors (type, start offset, length, last-of-run and end-of-stream
// flags). A byte is accepted every clock as long as the four-entry token
// queue between the front end and the output stage has room; the front end
// keeps the lexer mode, position and pending token, and finishes each byte
// in the cycle it is accepted. The tokens of a byte are written to the queue
// and then loaded into the output register once the output stage is free.
// The output stage delivers one token per clock while the sink is ready: a
// byte that closes a token and also yields one of its own sends both tokens
// out in turn, so the sustained rate is one byte per clock except when bytes
// causing two tokens arrive in a run, where the single output port sets it.
// A byte flagged end_of_input flushes any pending token and restarts the
// offsets at zero for the next byte.

module source_text_lexer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stl_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stl_pkg::token_t    out_data_o
);
  import stl_pkg::*;

  // front end to queue
  logic    push;
  bundle_t push_data;
  logic    full;
  // queue to output stage
  logic    pop;
  logic    nonempty;
  bundle_t pop_data;

  // classifies each byte and forms up to two tokens
  stl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_data_o   (push_data)
  );

  // short decoupling queue of token bundles
  stl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .nonempty_o  (nonempty),
    .pop_data_o  (pop_data)
  );

  // splits bundles into single token transfers
  stl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_nonempty_i (nonempty),
    .q_data_i     (pop_data),
    .q_pop_o      (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== rtl/stl_front.sv =====
`timescale 1ns / 1ps

module stl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  stl_pkg::in_item_t   in_data_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output stl_pkg::bundle_t    q_data_o
);
  import stl_pkg::*;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_PRE     = 3'd1;
  localparam logic [2:0] MODE_IDENT   = 3'd2;
  localparam logic [2:0] MODE_NUM     = 3'd3;
  localparam logic [2:0] MODE_STR     = 3'd4;
  localparam logic [2:0] MODE_SLASH   = 3'd5;
  localparam logic [2:0] MODE_COMMENT = 3'd6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_LBRC  = 8'h7b;
  localparam logic [7:0] CH_RBRC  = 8'h7d;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  logic [2:0]               mode_q, mode_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic [15:0]              len_q, len_d;
  logic [23:0]              pref_q, pref_d;

  logic [7:0] c;
  logic       eoi;
  logic       accept;
  logic       is_letter, is_digit;
  logic       run_idle;

  logic                     a_v, b_v;
  logic [3:0]               a_type, b_type;
  logic [POSITION_BITS-1:0] a_start, b_start;
  logic [15:0]              a_len, b_len;
  token_t                   a_tok, b_tok;

  function automatic logic [15:0] grow(input logic [15:0] len);
    return (len != 16'hffff) ? len + 16'd1 : len;
  endfunction

  assign c         = in_data_i.char_code;
  assign eoi       = in_data_i.end_of_input;
  assign in_ready_o = !q_full_i;
  assign accept    = in_valid_i && in_ready_o;
  assign is_letter = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  assign is_digit  = (c >= 8'h30 && c <= 8'h39);

  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    len_d    = len_q;
    pref_d   = pref_q;
    pos_d    = pos_q + POSITION_BITS'(1);
    run_idle = 1'b0;
    a_v      = 1'b0;
    a_type   = TOK_ERR;
    a_start  = start_q;
    a_len    = len_q;
    b_v      = 1'b0;
    b_type   = TOK_ERR;
    b_start  = pos_q;
    b_len    = 16'd1;

    // first: the byte against the token in progress
    unique case (mode_q)
      MODE_PRE: begin
        if (c == CH_NL) begin
          a_v      = 1'b1;
          a_type   = TOK_PRE;
          run_idle = 1'b1;
        end else begin
          len_d = grow(len_q);
        end
      end
      MODE_STR: begin
        len_d = grow(len_q);
        if (c == CH_QUOTE) begin
          a_v    = 1'b1;
          a_type = TOK_STR;
          a_len  = len_d;
          mode_d = MODE_IDLE;
        end
      end
      MODE_IDENT: begin
        if (is_letter || is_digit) begin
          len_d  = grow(len_q);
          pref_d = {pref_q[15:0], c};
        end else begin
          a_v      = 1'b1;
          a_type   = ident_type(len_q, pref_q);
          run_idle = 1'b1;
        end
      end
      MODE_NUM: begin
        if (is_digit || c == CH_DOT) begin
          len_d = grow(len_q);
        end else begin
          a_v      = 1'b1;
          a_type   = TOK_NUM;
          run_idle = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          mode_d = MODE_COMMENT;
        end else begin
          a_v      = 1'b1;
          a_type   = TOK_ARITH;
          a_len    = 16'd1;
          run_idle = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (c == CH_NL) mode_d = MODE_IDLE;
      end
      default: run_idle = 1'b1;
    endcase

    // then the byte lexed from idle
    if (run_idle) begin
      mode_d = MODE_IDLE;
      priority if (c == CH_SPACE || c == CH_NL || c == CH_TAB) begin
        mode_d = MODE_IDLE;
      end else if (c == CH_HASH || c == CH_QUOTE || c == CH_SLASH || is_letter || is_digit) begin
        priority if (c == CH_HASH)  mode_d = MODE_PRE;
        else if (c == CH_QUOTE)     mode_d = MODE_STR;
        else if (c == CH_SLASH)     mode_d = MODE_SLASH;
        else if (is_letter)         mode_d = MODE_IDENT;
        else                        mode_d = MODE_NUM;
        start_d = pos_q;
        len_d   = 16'd1;
        pref_d  = {16'd0, c};
      end else begin
        b_v = 1'b1;
        priority if (c == CH_SEMI) b_type = TOK_TERM;
        else if (c == CH_LPAR || c == CH_RPAR || c == CH_COMMA ||
                 c == CH_LBRK || c == CH_RBRK) b_type = TOK_PUNCT;
        else if (c == CH_PLUS || c == CH_MINUS || c == CH_PCT ||
                 c == CH_STAR) b_type = TOK_ARITH;
        else if (c == CH_LBRC || c == CH_RBRC) b_type = TOK_SCOPE;
        else b_type = TOK_ERR;
      end
    end

    // end of input flushes what is pending and restarts the stream
    if (eoi) begin
      b_start = start_d;
      b_len   = len_d;
      unique case (mode_d)
        MODE_PRE: begin
          b_v    = 1'b1;
          b_type = TOK_PRE;
        end
        MODE_IDENT: begin
          b_v    = 1'b1;
          b_type = ident_type(len_d, pref_d);
        end
        MODE_NUM: begin
          b_v    = 1'b1;
          b_type = TOK_NUM;
        end
        MODE_STR: begin
          b_v    = 1'b1;
          b_type = TOK_ERR;
        end
        MODE_SLASH: begin
          b_v    = 1'b1;
          b_type = TOK_ARITH;
          b_len  = 16'd1;
        end
        default: begin
          // idle after a single-byte token keeps that token
          b_start = pos_q;
          b_len   = 16'd1;
        end
      endcase
      mode_d  = MODE_IDLE;
      pos_d   = '0;
      start_d = '0;
      len_d   = '0;
      pref_d  = '0;
    end
  end

  always_comb begin
    a_tok = '{token_type: a_type, token_start: pos_to_start(a_start), token_length: a_len,
              last_of_run: !b_v, end_of_stream: !b_v && eoi};
    b_tok = '{token_type: b_type, token_start: pos_to_start(b_start), token_length: b_len,
              last_of_run: 1'b1, end_of_stream: eoi};
    q_data_o.tok0 = a_v ? a_tok : b_tok;
    q_data_o.tok1 = b_tok;
    q_data_o.two  = a_v && b_v;
  end

  assign q_push_o = accept && (a_v || b_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      pref_q  <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      pref_q  <= pref_d;
    end
  end

  a_eoi_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && eoi |=> pos_q == '0 && mode_q == MODE_IDLE)
    else $error("stream did not restart after end of input");

endmodule

// ===== rtl/stl_queue.sv =====
`timescale 1ns / 1ps

module stl_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  stl_pkg::bundle_t          push_data_i,
  output logic                      full_o,
  input  logic                      pop_i,
  output logic                      nonempty_o,
  output stl_pkg::bundle_t          pop_data_o
);
  import stl_pkg::*;

  bundle_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wptr_q, rptr_q;
  logic [QUEUE_AW:0]    count_q, count_d;
  queue_wr_status_t     wr_st;

  assign full_o     = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign nonempty_o = (count_q != '0);
  assign pop_data_o = mem_q[rptr_q];
  assign wr_st      = '{push: push_i, full: full_o};

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + (QUEUE_AW+1)'(1);
    else if (!push_i && pop_i) count_d = count_q - (QUEUE_AW+1)'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + QUEUE_AW'(1);
      if (pop_i)  rptr_q <= rptr_q + QUEUE_AW'(1);
      count_q <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_st.push |-> !wr_st.full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> nonempty_o)
    else $error("pop from an empty queue");

endmodule

// ===== rtl/stl_back.sv =====
`timescale 1ns / 1ps

module stl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_nonempty_i,
  input  stl_pkg::bundle_t    q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output stl_pkg::token_t     out_data_o
);
  import stl_pkg::*;

  logic   out_valid_q, out_valid_d;
  token_t out_tok_q, out_tok_d;
  logic   pend_valid_q, pend_valid_d;
  token_t pend_tok_q, pend_tok_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;
  assign q_pop_o  = out_free && !pend_valid_q && q_nonempty_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_tok_d    = out_tok_q;
    pend_valid_d = pend_valid_q;
    pend_tok_d   = pend_tok_q;
    if (out_free) begin
      priority if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_tok_d    = pend_tok_q;
        pend_valid_d = 1'b0;
      end else if (q_nonempty_i) begin
        out_valid_d  = 1'b1;
        out_tok_d    = q_data_i.tok0;
        pend_valid_d = q_data_i.two;
        pend_tok_d   = q_data_i.tok1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_tok_q  <= out_tok_d;
    pend_tok_q <= pend_tok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_tok_q;

  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q && !out_tok_q.last_of_run)
    else $error("second token pending without its first on the output");

  a_eos_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_tok_q.end_of_stream |-> out_tok_q.last_of_run)
    else $error("end of stream on a token that is not last of its run");

endmodule
